// ===== hw/rtl/iirdf1_pkg.sv =====
package iirdf1_pkg;

	localparam int FRAC_SHIFT   = 14;
	localparam int ORDER_BITS   = 6;
	localparam int TAP_BITS     = 6;
	localparam int OP_BITS      = 2;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_FF_ORDER = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_FB_ORDER = CFG_IDX_BITS'(1);

	typedef enum logic [OP_BITS-1:0] {
		OP_SAMPLE  = 2'd0,
		OP_FF_COEF = 2'd1,
		OP_FB_COEF = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FF,
		ST_FB,
		ST_DRAIN,
		ST_ROUND,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic load_sample;
		logic clr_acc;
		logic issue;
		logic use_sample;
		logic feedback;
		logic round;
		logic commit;
		logic wr_ff_coef;
		logic wr_fb_coef;
		logic clr_hist;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

// ===== hw/rtl/iirdf1_ctrl.sv =====
module iirdf1_ctrl #(
	parameter int MAX_ORDER = 32,
	localparam int CW = $clog2(MAX_ORDER + 1)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  iirdf1_pkg::op_t                        opcode,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [iirdf1_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [iirdf1_pkg::ORDER_BITS-1:0]      cfg_data,
	input  iirdf1_pkg::status_t                    status,
	output iirdf1_pkg::cmd_t                       cmd,
	output logic [CW-1:0]                          tap
);

	iirdf1_pkg::state_t state_q, state_d;
	logic [CW-1:0] k_q, k_d;
	logic drain_q, drain_d;
	logic [iirdf1_pkg::ORDER_BITS-1:0] ff_order_q, fb_order_q;
	logic [CW-1:0] m_ord, n_ord;

	assign cfg_ready = 1'b1;
	assign tap = k_q;

	// orders above the storage depth are clipped when used
	assign m_ord = (32'(ff_order_q) > MAX_ORDER) ? CW'(MAX_ORDER) : CW'(ff_order_q);
	assign n_ord = (32'(fb_order_q) > MAX_ORDER) ? CW'(MAX_ORDER) : CW'(fb_order_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_order_q <= '0;
			fb_order_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				iirdf1_pkg::REG_FF_ORDER: ff_order_q <= cfg_data;
				iirdf1_pkg::REG_FB_ORDER: fb_order_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iirdf1_pkg::ST_IDLE;
			k_q     <= '0;
			drain_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			drain_q <= drain_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		drain_d  = drain_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			iirdf1_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (opcode)
						iirdf1_pkg::OP_SAMPLE: begin
							cmd.load_sample = 1'b1;
							cmd.clr_acc     = 1'b1;
							k_d             = '0;
							state_d         = iirdf1_pkg::ST_FF;
						end
						iirdf1_pkg::OP_FF_COEF: cmd.wr_ff_coef = 1'b1;
						iirdf1_pkg::OP_FB_COEF: cmd.wr_fb_coef = 1'b1;
						iirdf1_pkg::OP_CLEAR:   cmd.clr_hist   = 1'b1;
						default: ;
					endcase
				end
			end
			iirdf1_pkg::ST_FF: begin
				cmd.issue      = 1'b1;
				cmd.use_sample = (k_q == '0);
				if (k_q == m_ord) begin
					drain_d = 1'b0;
					if (n_ord != '0) begin
						k_d     = CW'(1);
						state_d = iirdf1_pkg::ST_FB;
					end else begin
						state_d = iirdf1_pkg::ST_DRAIN;
					end
				end else begin
					k_d = k_q + CW'(1);
				end
			end
			iirdf1_pkg::ST_FB: begin
				cmd.issue    = 1'b1;
				cmd.feedback = 1'b1;
				if (k_q == n_ord) begin
					drain_d = 1'b0;
					state_d = iirdf1_pkg::ST_DRAIN;
				end else begin
					k_d = k_q + CW'(1);
				end
			end
			iirdf1_pkg::ST_DRAIN: begin
				// wait for the read and multiply stages to empty
				if (drain_q) begin
					state_d = iirdf1_pkg::ST_ROUND;
				end else begin
					drain_d = 1'b1;
				end
			end
			iirdf1_pkg::ST_ROUND: begin
				cmd.round = 1'b1;
				state_d   = iirdf1_pkg::ST_COMMIT;
			end
			iirdf1_pkg::ST_COMMIT: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = iirdf1_pkg::ST_IDLE;
				end
			end
			default: state_d = iirdf1_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/iirdf1_dp.sv =====
module iirdf1_dp #(
	parameter int MAX_ORDER   = 32,
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 18,
	localparam int CW = $clog2(MAX_ORDER + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  iirdf1_pkg::cmd_t                    cmd,
	input  logic [CW-1:0]                       tap,
	input  logic [iirdf1_pkg::TAP_BITS-1:0]     tap_index,
	input  logic signed [COEF_BITS-1:0]         coef_value,
	input  logic signed [SAMPLE_BITS-1:0]       sample_in,
	output iirdf1_pkg::status_t                 status,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [SAMPLE_BITS-1:0]              sample_out,
	output logic                                saturated
);

	localparam int HW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int PW = SAMPLE_BITS + COEF_BITS;
	localparam int AW_SUM = PW + $clog2(2 * MAX_ORDER + 2);
	localparam int AW_MIN = SAMPLE_BITS + iirdf1_pkg::FRAC_SHIFT + 1;
	localparam int AW = (AW_SUM > AW_MIN) ? AW_SUM : AW_MIN;
	localparam int RW = AW - iirdf1_pkg::FRAC_SHIFT;
	localparam logic signed [AW-1:0] RND_HALF = AW'(2 ** (iirdf1_pkg::FRAC_SHIFT - 1));

	logic signed [COEF_BITS-1:0] bmem [MAX_ORDER+1];
	logic signed [COEF_BITS-1:0] amem [MAX_ORDER+1];
	logic [MAX_ORDER:0] bv_q, av_q;
	logic signed [SAMPLE_BITS-1:0] xmem [MAX_ORDER];
	logic signed [SAMPLE_BITS-1:0] ymem [MAX_ORDER];

	logic [HW-1:0] wp_q;
	logic [CW-1:0] cnt_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;

	logic [31:0] tap32;
	logic tap_ok;
	logic [CW-1:0] wr_addr;
	int hist_sum;
	logic [HW-1:0] hist_addr;

	logic vld_s1, use_sample_s1, fb_s1;
	logic bv_s1, av_s1, hv_s1;
	logic signed [COEF_BITS-1:0] bcoef_s1, acoef_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1, y_s1;
	logic signed [COEF_BITS-1:0] coef_op;
	logic signed [SAMPLE_BITS-1:0] data_op;

	logic vld_s2, fb_s2;
	logic signed [PW-1:0] prod_s2;

	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] acc_rnd;
	logic signed [RW-1:0] rnd_q;
	logic fits;
	logic [SAMPLE_BITS-1:0] y_sat;

	logic out_vld_q;
	logic [SAMPLE_BITS-1:0] out_sample_q;
	logic out_sat_q;

	assign tap32   = 32'(tap_index);
	assign tap_ok  = (tap32 <= 32'(MAX_ORDER));
	assign wr_addr = tap32[CW-1:0];

	// x[n-k] and y[n-k] sit k entries behind the write pointer
	assign hist_sum  = int'(wp_q) + MAX_ORDER - int'(tap);
	assign hist_addr = (hist_sum >= MAX_ORDER) ? HW'(hist_sum - MAX_ORDER) : HW'(hist_sum);

	// coefficient stores
	always_ff @(posedge clk) begin
		if (cmd.wr_ff_coef && tap_ok) begin
			bmem[wr_addr] <= coef_value;
		end
		if (cmd.wr_fb_coef && tap_ok) begin
			amem[wr_addr] <= coef_value;
		end
		bcoef_s1 <= bmem[tap];
		acoef_s1 <= amem[tap];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_q <= '0;
			av_q <= '0;
		end else begin
			if (cmd.wr_ff_coef && tap_ok) begin
				bv_q[wr_addr] <= 1'b1;
			end
			if (cmd.wr_fb_coef && tap_ok) begin
				av_q[wr_addr] <= 1'b1;
			end
		end
	end

	// history stores, circular
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			xmem[wp_q] <= sample_q;
			ymem[wp_q] <= y_sat;
		end
		x_s1 <= xmem[hist_addr];
		y_s1 <= ymem[hist_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.clr_hist) begin
			cnt_q <= '0;
		end else if (cmd.commit) begin
			wp_q <= (32'(wp_q) == 32'(MAX_ORDER - 1)) ? '0 : wp_q + HW'(1);
			if (32'(cnt_q) != 32'(MAX_ORDER)) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			sample_q <= sample_in;
		end
		use_sample_s1 <= cmd.use_sample;
		fb_s1         <= cmd.feedback;
		bv_s1         <= bv_q[tap];
		av_s1         <= av_q[tap];
		hv_s1         <= (tap <= cnt_q);
	end

	always_comb begin
		if (fb_s1) begin
			coef_op = av_s1 ? acoef_s1 : '0;
			data_op = hv_s1 ? y_s1 : '0;
		end else begin
			coef_op = bv_s1 ? bcoef_s1 : '0;
			data_op = use_sample_s1 ? sample_q : (hv_s1 ? x_s1 : '0);
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PW'(coef_op) * PW'(data_op);
		fb_s2   <= fb_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_acc) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			if (fb_s2) begin
				acc_q <= acc_q - AW'(prod_s2);
			end else begin
				acc_q <= acc_q + AW'(prod_s2);
			end
		end
	end

	// round half up, then drop the fraction bits
	assign acc_rnd = acc_q + RND_HALF;

	always_ff @(posedge clk) begin
		if (cmd.round) begin
			rnd_q <= acc_rnd[AW-1:iirdf1_pkg::FRAC_SHIFT];
		end
	end

	assign fits  = (rnd_q[RW-1:SAMPLE_BITS-1] == '0) || (rnd_q[RW-1:SAMPLE_BITS-1] == '1);
	assign y_sat = fits ? rnd_q[SAMPLE_BITS-1:0]
		: {rnd_q[RW-1], {(SAMPLE_BITS-1){~rnd_q[RW-1]}}};

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_sample_q <= y_sat;
			out_sat_q    <= ~fits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.commit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign status.out_free = !out_vld_q || m_tready;
	assign m_tvalid   = out_vld_q;
	assign sample_out = out_sample_q;
	assign saturated  = out_sat_q;

endmodule

// ===== hw/rtl/iir_direct_form_one_filter_core.sv =====
// Direct form I IIR filter with one shared multiply-accumulate.
// A sample walks feed-forward taps 0..M, then feedback taps 1..N (M, N the clipped
// orders) through the single MAC, drains, rounds and commits once the output is
// free. No new item is taken until the sample commits; writes and clears do not stall.
// Reset: orders zero, histories and coefficients read as zero, no item pending.
module iir_direct_form_one_filter_core #(
	parameter int MAX_ORDER   = 32,
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 18,
	localparam int IN_W  = ((iirdf1_pkg::TAP_BITS + COEF_BITS + SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [IN_W-1:0]                      s_tdata,  // tap_index, coef_value, sample_in
	input  logic [iirdf1_pkg::OP_BITS-1:0]       s_tuser,  // opcode
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [OUT_W-1:0]                     m_tdata,  // sample_out
	output logic [0:0]                           m_tuser,  // saturated
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [iirdf1_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [iirdf1_pkg::ORDER_BITS-1:0]    cfg_data
);

	localparam int CW = $clog2(MAX_ORDER + 1);
	localparam int COEF_LO = iirdf1_pkg::TAP_BITS;
	localparam int SAMP_LO = COEF_LO + COEF_BITS;

	iirdf1_pkg::cmd_t cmd;
	iirdf1_pkg::status_t status;
	logic [CW-1:0] tap;
	logic [SAMPLE_BITS-1:0] sample_out;
	logic saturated;

	iirdf1_ctrl #(
		.MAX_ORDER(MAX_ORDER)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.opcode    (iirdf1_pkg::op_t'(s_tuser)),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.cmd       (cmd),
		.tap       (tap)
	);

	iirdf1_dp #(
		.MAX_ORDER   (MAX_ORDER),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.tap        (tap),
		.tap_index  (s_tdata[iirdf1_pkg::TAP_BITS-1:0]),
		.coef_value (s_tdata[SAMP_LO-1:COEF_LO]),
		.sample_in  (s_tdata[SAMP_LO+SAMPLE_BITS-1:SAMP_LO]),
		.status     (status),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.sample_out (sample_out),
		.saturated  (saturated)
	);

	assign m_tdata    = OUT_W'(sample_out);
	assign m_tuser[0] = saturated;

	// a sample blocks further items until its result is committed
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == iirdf1_pkg::OP_SAMPLE) |=> !s_tready)
		else $error("input accepted while a sample is in flight");

	// a result only appears after a commit
	a_out_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.commit))
		else $error("output valid without commit");

	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_tvalid || m_tready))
		else $error("commit over a pending result");

endmodule

// ===== verif/iir_direct_form_one_filter_core_test.sv =====
`timescale 1ns / 1ps

module iir_direct_form_one_filter_core_test;

	localparam int TAPS         = 32;
	localparam int DRAIN_CYCLES = 80;   // long enough for a trailing sample to finish at the top orders
	localparam int STALL_LIMIT  = 3000;

	// indexes past the register list; writes there must be ignored
	localparam logic [iirdf1_pkg::CFG_IDX_BITS-1:0] REG_UNMAPPED_LO =
		iirdf1_pkg::CFG_IDX_BITS'(2);
	localparam logic [iirdf1_pkg::CFG_IDX_BITS-1:0] REG_UNMAPPED_HI =
		iirdf1_pkg::CFG_IDX_BITS'(3);

	typedef struct {
		iirdf1_pkg::op_t    op;
		logic [5:0]         tap;
		logic signed [17:0] coef;
		logic signed [15:0] smp;
	} filter_item_t;

	typedef struct {
		logic [15:0] value;
		logic        sat;
	} filtered_sample_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [5:0]  cfg_data  = '0;

	iir_direct_form_one_filter_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// filter state as the block should hold it
	logic [5:0]         ff_order;
	logic [5:0]         fb_order;
	logic signed [15:0] x_hist [0:TAPS-1];
	logic signed [15:0] y_hist [0:TAPS-1];
	logic signed [17:0] ff_coef [0:TAPS];
	logic signed [17:0] fb_coef [0:TAPS];

	filter_item_t     pending_items [$];
	filtered_sample_t expected_outputs [$];
	filter_item_t     cur_item;

	int  queued_count   = 0;
	int  accepted_count = 0;
	int  sample_count   = 0;
	int  sat_count      = 0;
	int  settings_count = 0;
	int  errors         = 0;
	int  src_gap        = 0;
	int  sink_left      = 0;
	int  idle_cycles    = 0;
	bit  sink_ready     = 1'b0;
	bit  quiet          = 1'b0;
	bit  next_valid;

	function automatic void filter_clear_state();
		ff_order = '0;
		fb_order = '0;
		for (int k = 0; k < TAPS; k++) begin
			x_hist[k] = '0;
			y_hist[k] = '0;
		end
		for (int k = 0; k <= TAPS; k++) begin
			ff_coef[k] = '0;
			fb_coef[k] = '0;
		end
	endfunction

	// apply one accepted item; samples push the filtered value they produce
	function automatic void filter_apply(filter_item_t it);
		longint           acc;
		longint           yv;
		int               m;
		int               n;
		filtered_sample_t res;
		case (it.op)
			iirdf1_pkg::OP_FF_COEF: begin
				if (it.tap <= TAPS) ff_coef[it.tap] = it.coef;
			end
			iirdf1_pkg::OP_FB_COEF: begin
				if (it.tap <= TAPS) fb_coef[it.tap] = it.coef;
			end
			iirdf1_pkg::OP_CLEAR: begin
				for (int k = 0; k < TAPS; k++) begin
					x_hist[k] = '0;
					y_hist[k] = '0;
				end
			end
			default: begin
				m = (ff_order > TAPS) ? TAPS : int'(ff_order);
				n = (fb_order > TAPS) ? TAPS : int'(fb_order);
				acc = longint'(ff_coef[0]) * longint'(it.smp);
				for (int k = 1; k <= m; k++)
					acc += longint'(ff_coef[k]) * longint'(x_hist[k-1]);
				for (int k = 1; k <= n; k++)
					acc -= longint'(fb_coef[k]) * longint'(y_hist[k-1]);
				// tie rounds toward plus infinity; >>> floors
				yv = (acc + (longint'(1) << (iirdf1_pkg::FRAC_SHIFT - 1)))
					>>> iirdf1_pkg::FRAC_SHIFT;
				res.sat = 1'b0;
				if (yv > 32767) begin
					yv = 32767;
					res.sat = 1'b1;
				end
				if (yv < -32768) begin
					yv = -32768;
					res.sat = 1'b1;
				end
				res.value = yv[15:0];
				for (int k = TAPS - 1; k > 0; k--) begin
					x_hist[k] = x_hist[k-1];
					y_hist[k] = y_hist[k-1];
				end
				x_hist[0] = it.smp;
				y_hist[0] = yv[15:0];
				expected_outputs.push_back(res);
				sample_count++;
				if (res.sat) sat_count++;
			end
		endcase
	endfunction

	// fields not used by the opcode carry random junk
	task automatic queue_item(input iirdf1_pkg::op_t op, input int tap, input int coef,
		input int smp);
		filter_item_t it;
		it.op   = op;
		it.tap  = (tap < 0) ? 6'($urandom) : 6'(tap);
		it.coef = (op == iirdf1_pkg::OP_FF_COEF || op == iirdf1_pkg::OP_FB_COEF) ?
			18'(coef) : 18'($urandom);
		it.smp  = (op == iirdf1_pkg::OP_SAMPLE) ? 16'(smp) : 16'($urandom);
		pending_items.push_back(it);
		queued_count++;
	endtask

	function automatic int rand_coef();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return int'($urandom_range(0, 2047)) - 1024;
		if (r < 9) return int'($urandom_range(0, 262143)) - 131072;
		return ($urandom_range(0, 1) != 0) ? 131071 : -131072;
	endfunction

	function automatic int rand_sample();
		if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 511)) - 256;
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == iirdf1_pkg::REG_FF_ORDER) ff_order = val;
		else if (idx == iirdf1_pkg::REG_FB_ORDER) fb_order = val;
	endtask

	// all items taken, all outputs seen, then let a trailing item finish
	task automatic wait_idle();
		do @(posedge clk);
		while (accepted_count != queued_count || expected_outputs.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_setting(input int ffo, input int fbo, input int nmix, input bit load);
		int top;
		int r;
		wait_idle();
		write_reg(iirdf1_pkg::REG_FF_ORDER, 6'(ffo));
		write_reg(iirdf1_pkg::REG_FB_ORDER, 6'(fbo));
		if ($urandom_range(0, 2) == 0)
			write_reg(($urandom_range(0, 1) != 0) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
				6'($urandom));
		settings_count++;
		if (load) begin
			top = (ffo > fbo) ? ffo : fbo;
			if (top > TAPS) top = TAPS;
			for (int k = 0; k <= top; k++) begin
				queue_item(iirdf1_pkg::OP_FF_COEF, k, rand_coef(), 0);
				if (k > 0) queue_item(iirdf1_pkg::OP_FB_COEF, k, rand_coef(), 0);
			end
			queue_item(iirdf1_pkg::OP_CLEAR, -1, 0, 0);
		end
		for (int i = 0; i < nmix; i++) begin
			r = $urandom_range(0, 99);
			if (r < 80) queue_item(iirdf1_pkg::OP_SAMPLE, -1, 0, rand_sample());
			else if (r < 87) queue_item(iirdf1_pkg::OP_CLEAR, -1, 0, 0);
			else if (r < 94)
				queue_item(iirdf1_pkg::OP_FF_COEF, $urandom_range(0, 63), rand_coef(), 0);
			else
				queue_item(iirdf1_pkg::OP_FB_COEF, $urandom_range(0, 63), rand_coef(), 0);
		end
	endtask

	// source side: holds an item until taken, idles in bursts between items
	always @(posedge clk) begin
		if (arst_n) begin
			next_valid = s_tvalid;
			if (s_tvalid && s_tready) begin
				filter_apply(cur_item);
				accepted_count++;
				next_valid = 1'b0;
				if (!quiet && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 16);
			end
			if (!next_valid) begin
				if (src_gap != 0) begin
					src_gap--;
				end else if (pending_items.size() != 0) begin
					cur_item = pending_items.pop_front();
					next_valid = 1'b1;
					s_tdata <= {cur_item.smp, cur_item.coef, cur_item.tap};
					s_tuser <= cur_item.op;
				end
			end
			s_tvalid <= next_valid;
		end
	end

	// sink side: ready and stall come in bursts
	always @(posedge clk) begin
		if (sink_left == 0) begin
			sink_left  = $urandom_range(1, 16);
			sink_ready = quiet || ($urandom_range(0, 2) != 0);
		end else begin
			sink_left--;
		end
		m_tready <= sink_ready || quiet;
	end

	always @(posedge clk) begin
		filtered_sample_t exp_out;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_outputs.size() == 0) begin
				$display("%0t: unexpected item, actual sample_out %h saturated %b",
					$time, m_tdata, m_tuser[0]);
				errors++;
			end else begin
				exp_out = expected_outputs.pop_front();
				if (m_tdata !== exp_out.value) begin
					$display("%0t: sample_out mismatch, expected %h actual %h",
						$time, exp_out.value, m_tdata);
					errors++;
				end
				if (m_tuser[0] !== exp_out.sat) begin
					$display("%0t: saturated mismatch, expected %b actual %b",
						$time, exp_out.sat, m_tuser[0]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, idle_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		filter_clear_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// orders still zero: only b[0] counts, drive both saturation rails
		queue_item(iirdf1_pkg::OP_SAMPLE, -1, 0, 32767);
		queue_item(iirdf1_pkg::OP_FF_COEF, 0, 131071, 0);
		queue_item(iirdf1_pkg::OP_SAMPLE, -1, 0, 32767);
		queue_item(iirdf1_pkg::OP_SAMPLE, -1, 0, -32768);
		queue_item(iirdf1_pkg::OP_FF_COEF, 0, -131072, 0);
		queue_item(iirdf1_pkg::OP_SAMPLE, -1, 0, -32768);
		queue_item(iirdf1_pkg::OP_SAMPLE, -1, 0, 32767);
		wait_idle();
		write_reg(iirdf1_pkg::REG_FF_ORDER, 6'd2);
		write_reg(iirdf1_pkg::REG_FB_ORDER, 6'd1);
		settings_count++;
		// b[0] = 0.5 makes odd samples land on rounding ties
		queue_item(iirdf1_pkg::OP_FF_COEF, 0, 8192, 0);
		queue_item(iirdf1_pkg::OP_SAMPLE, -1, 0, 1);
		queue_item(iirdf1_pkg::OP_SAMPLE, -1, 0, -1);
		queue_item(iirdf1_pkg::OP_SAMPLE, -1, 0, 3);
		queue_item(iirdf1_pkg::OP_SAMPLE, -1, 0, -3);
		queue_item(iirdf1_pkg::OP_FF_COEF, 1, 16384, 0);
		queue_item(iirdf1_pkg::OP_FF_COEF, 2, -16384, 0);
		queue_item(iirdf1_pkg::OP_FB_COEF, 1, 8192, 0);
		queue_item(iirdf1_pkg::OP_FB_COEF, 0, 12345, 0);       // a[0] never enters the sum
		queue_item(iirdf1_pkg::OP_FF_COEF, 33, 9999, 0);       // tap past the top: dropped
		queue_item(iirdf1_pkg::OP_FB_COEF, 63, -131072, 0);    // dropped as well
		queue_item(iirdf1_pkg::OP_FF_COEF, 32, 777, 0);
		queue_item(iirdf1_pkg::OP_SAMPLE, -1, 0, 20000);
		queue_item(iirdf1_pkg::OP_SAMPLE, -1, 0, -20000);
		queue_item(iirdf1_pkg::OP_SAMPLE, -1, 0, 32767);
		queue_item(iirdf1_pkg::OP_CLEAR, -1, 0, 0);
		queue_item(iirdf1_pkg::OP_SAMPLE, -1, 0, 100);

		run_setting(32, 32, 40, 1'b1);
		run_setting(0, 0, 40, 1'b1);
		run_setting(63, 40, 40, 1'b1);   // both orders clip to the top tap
		run_setting(33, 1, 40, 1'b0);
		for (int p = 0; p < 4; p++) begin
			if (p == 3) begin
				wait_idle();
				quiet = 1'b1;
			end
			if ($urandom_range(0, 4) == 0)
				run_setting($urandom_range(0, 63), $urandom_range(0, 63), 40, 1'b1);
			else
				run_setting($urandom_range(0, 6), $urandom_range(0, 6), 40, 1'b1);
		end
		wait_idle();

		$display("covered %0d items, %0d filtered samples (%0d saturated)",
			accepted_count, sample_count, sat_count);
		$display("across %0d order settings with random source gaps and sink stalls",
			settings_count);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/iirdf1_pkg.sv
hw/rtl/iirdf1_ctrl.sv
hw/rtl/iirdf1_dp.sv
hw/rtl/iir_direct_form_one_filter_core.sv
verif/iir_direct_form_one_filter_core_test.sv
